[src/ffba_pkg.sv]
// shared types and constants for the first-fit block allocator
// header word layout, memory port request and result bundles
// no dependencies
package ffba_pkg;

    localparam int ARENA_BYTES  = 1024;
    localparam int HEADER_BYTES = 24;
    localparam int OFS_W        = 10;
    localparam int SIZE_W       = 10;
    localparam int NEED_W       = OFS_W + 1;
    localparam int SUM_W        = OFS_W + 2;

    typedef logic [OFS_W-1:0]  ofs_t;
    typedef logic [SIZE_W-1:0] size_t;
    typedef logic [NEED_W-1:0] need_t;
    typedef logic [SUM_W-1:0]  sum_t;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NO_SPACE = 1'b1;

    typedef struct packed {
        logic  has_next;
        ofs_t  next;
        logic  is_free;
        size_t size;
    } hdr_t;

    localparam hdr_t ROOT_HDR = '{
        has_next: 1'b0,
        next:     '0,
        is_free:  1'b1,
        size:     SIZE_W'(ARENA_BYTES - HEADER_BYTES)
    };

    typedef struct packed {
        logic wr_en;
        ofs_t wr_addr;
        hdr_t wr_data;
        logic rd_en;
        ofs_t rd_addr;
    } ram_req_t;

    typedef struct packed {
        logic done;
        logic status;
        ofs_t offset;
    } result_t;

endpackage

[src/first_fit_block_allocator.sv]
// first-fit block allocator with coalescing, top level
// instantiates ffba_ctrl and ffba_hdr_ram, holds the result word register
// depends on ffba_pkg
//
// input channel s_*: one request word per handshake; s_operation selects
// allocate (s_request_size payload bytes) or free (s_address payload offset).
// result channel m_*: exactly one word per request, in order; m_status flags
// an allocate with no fitting free block, m_payload_offset gives the granted
// payload offset and is zero on failure and on every free.
// the arena is a chain of headers in a header memory with registered read
// data; the walker visits one header per cycle. an allocate walks to the first
// free block that fits and writes the remainder header (when it lies inside
// the arena) and the granted header. a free walks to its block, marks it free
// and walks the whole chain again from the root to merge free neighbours; a
// free of a block not in the chain walks the chain and changes nothing, and a
// free below the header size goes straight to the result. one request is
// worked on at a time; s_ready is high only while idle, rising with m_valid.
// the result register lets the walker finish while m_ready is low; a new word
// is taken once the walker is idle, and its result waits until the register
// is emptied. after reset the arena holds one free block covering it all;
// no clearing pass is needed.
module first_fit_block_allocator (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_operation,
    input  logic [ffba_pkg::OFS_W-1:0] s_request_size,
    input  logic [ffba_pkg::OFS_W-1:0] s_address,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_status,
    output logic [ffba_pkg::OFS_W-1:0] m_payload_offset
);
    import ffba_pkg::*;

    ram_req_t ram_req;
    hdr_t     rd_data;
    result_t  result;
    logic     out_free;
    logic     m_valid_reg;
    logic     m_status_reg;
    ofs_t     m_offset_reg;

    assign out_free = !m_valid_reg || m_ready;

    ffba_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_request_size (s_request_size),
        .s_address      (s_address),
        .out_free       (out_free),
        .rd_data        (rd_data),
        .ram_req        (ram_req),
        .result         (result)
    );

    ffba_hdr_ram u_hdr_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (result.done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (result.done) begin
            m_status_reg <= result.status;
            m_offset_reg <= result.offset;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_payload_offset = m_offset_reg;

endmodule

[src/ffba_hdr_ram.sv]
// header memory: one write and one read port, registered read data
// write-to-read forwarding and a reset value for the root entry
// depends on ffba_pkg
module ffba_hdr_ram (
    input  logic              aclk,
    input  logic              aresetn,
    input  ffba_pkg::ram_req_t req,
    output ffba_pkg::hdr_t     rd_data
);
    import ffba_pkg::*;

    hdr_t mem [ARENA_BYTES];
    hdr_t rd_q_reg;
    logic root_written_reg;
    logic rd_root_reg;
    logic wr_hits_rd;
    logic wr_root;

    assign wr_hits_rd = req.wr_en && (req.wr_addr == req.rd_addr);
    assign wr_root    = req.wr_en && (req.wr_addr == '0);

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            if (wr_hits_rd) begin
                rd_q_reg <= req.wr_data;
            end else begin
                rd_q_reg <= mem[req.rd_addr];
            end
        end
    end

    // root entry reads as its reset value until first written
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_written_reg <= 1'b0;
            rd_root_reg      <= 1'b0;
        end else begin
            if (wr_root) begin
                root_written_reg <= 1'b1;
            end
            if (req.rd_en) begin
                rd_root_reg <= (req.rd_addr == '0) && !root_written_reg && !wr_root;
            end
        end
    end

    assign rd_data = rd_root_reg ? ROOT_HDR : rd_q_reg;

endmodule

[src/ffba_ctrl.sv]
// chain walker: first-fit search and split, free lookup and coalescing pass
// reads, modifies and writes back headers through ffba_hdr_ram
// depends on ffba_pkg
module ffba_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_operation,
    input  logic [ffba_pkg::OFS_W-1:0] s_request_size,
    input  logic [ffba_pkg::OFS_W-1:0] s_address,
    input  logic                       out_free,
    input  ffba_pkg::hdr_t             rd_data,
    output ffba_pkg::ram_req_t         ram_req,
    output ffba_pkg::result_t          result
);
    import ffba_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_A_CHK   = 8'b0000_0010,
        ST_A_SPLIT = 8'b0000_0100,
        ST_A_FRONT = 8'b0000_1000,
        ST_F_CHK   = 8'b0001_0000,
        ST_C_CUR   = 8'b0010_0000,
        ST_C_NXT   = 8'b0100_0000,
        ST_OUT     = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    ofs_t   cur_reg, cur_next;
    hdr_t   hdr_reg, hdr_next;
    ofs_t   req_reg, req_next;
    ofs_t   target_reg, target_next;
    logic   status_reg, status_next;
    ofs_t   offset_reg, offset_next;

    need_t  need;
    sum_t   nb;
    logic   nb_fits;
    logic   fits;
    size_t  merged_size;

    assign need        = NEED_W'(req_reg) + NEED_W'(HEADER_BYTES);
    assign nb          = SUM_W'(cur_reg) + SUM_W'(need);
    assign nb_fits     = nb < SUM_W'(ARENA_BYTES);
    assign fits        = NEED_W'(rd_data.size) >= need;
    assign merged_size = SIZE_W'(SUM_W'(hdr_reg.size) + SUM_W'(HEADER_BYTES)
                                 + SUM_W'(rd_data.size));

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        hdr_next    = hdr_reg;
        req_next    = req_reg;
        target_next = target_reg;
        status_next = status_reg;
        offset_next = offset_reg;
        ram_req     = '0;
        result      = '0;
        result.status = status_reg;
        result.offset = offset_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next    = s_request_size;
                    status_next = STATUS_OK;
                    offset_next = '0;
                    cur_next    = '0;
                    if (s_operation == OP_ALLOC) begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = '0;
                        state_next      = ST_A_CHK;
                    end else if (s_address < OFS_W'(HEADER_BYTES)) begin
                        state_next = ST_OUT;
                    end else begin
                        target_next     = s_address - OFS_W'(HEADER_BYTES);
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = '0;
                        state_next      = ST_F_CHK;
                    end
                end
            end
            ST_A_CHK: begin
                hdr_next = rd_data;
                if (rd_data.is_free && fits) begin
                    state_next = ST_A_SPLIT;
                end else if (rd_data.has_next) begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = rd_data.next;
                    cur_next        = rd_data.next;
                end else begin
                    status_next = STATUS_NO_SPACE;
                    state_next  = ST_OUT;
                end
            end
            ST_A_SPLIT: begin
                offset_next   = cur_reg + OFS_W'(HEADER_BYTES);
                ram_req.wr_en = 1'b1;
                if (nb_fits) begin
                    // remainder becomes a free block behind the granted one
                    ram_req.wr_addr          = OFS_W'(nb);
                    ram_req.wr_data.has_next = hdr_reg.has_next;
                    ram_req.wr_data.next     = hdr_reg.next;
                    ram_req.wr_data.is_free  = 1'b1;
                    ram_req.wr_data.size     = SIZE_W'(NEED_W'(hdr_reg.size) - need);
                    state_next               = ST_A_FRONT;
                end else begin
                    ram_req.wr_addr          = cur_reg;
                    ram_req.wr_data.has_next = hdr_reg.has_next;
                    ram_req.wr_data.next     = hdr_reg.next;
                    ram_req.wr_data.is_free  = 1'b0;
                    ram_req.wr_data.size     = req_reg;
                    state_next               = ST_OUT;
                end
            end
            ST_A_FRONT: begin
                ram_req.wr_en            = 1'b1;
                ram_req.wr_addr          = cur_reg;
                ram_req.wr_data.has_next = 1'b1;
                ram_req.wr_data.next     = OFS_W'(nb);
                ram_req.wr_data.is_free  = 1'b0;
                ram_req.wr_data.size     = req_reg;
                state_next               = ST_OUT;
            end
            ST_F_CHK: begin
                if (cur_reg == target_reg) begin
                    // mark free and restart from the root for coalescing
                    ram_req.wr_en           = 1'b1;
                    ram_req.wr_addr         = cur_reg;
                    ram_req.wr_data         = rd_data;
                    ram_req.wr_data.is_free = 1'b1;
                    ram_req.rd_en           = 1'b1;
                    ram_req.rd_addr         = '0;
                    cur_next                = '0;
                    state_next              = ST_C_CUR;
                end else if (rd_data.has_next) begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = rd_data.next;
                    cur_next        = rd_data.next;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_C_CUR: begin
                hdr_next = rd_data;
                if (rd_data.has_next) begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = rd_data.next;
                    state_next      = ST_C_NXT;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_C_NXT: begin
                if (hdr_reg.is_free && rd_data.is_free) begin
                    hdr_next.has_next = rd_data.has_next;
                    hdr_next.next     = rd_data.next;
                    hdr_next.is_free  = 1'b1;
                    hdr_next.size     = merged_size;
                    ram_req.wr_en     = 1'b1;
                    ram_req.wr_addr   = cur_reg;
                    ram_req.wr_data   = hdr_next;
                end else begin
                    cur_next = hdr_reg.next;
                    hdr_next = rd_data;
                end
                // either way the following header is the one after rd_data
                if (rd_data.has_next) begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = rd_data.next;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    result.done = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        hdr_reg    <= hdr_next;
        req_reg    <= req_next;
        target_reg <= target_next;
        status_reg <= status_next;
        offset_reg <= offset_next;
    end

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg != ST_IDLE)
        else $error("accepted word did not start a walk");

    a_read_consumed: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_req.rd_en |=> (state_reg == ST_A_CHK) || (state_reg == ST_F_CHK) ||
                          (state_reg == ST_C_CUR) || (state_reg == ST_C_NXT))
        else $error("header read issued with nobody to take the data");

    a_same_entry_only_on_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_req.wr_en && ram_req.rd_en && (ram_req.wr_addr == ram_req.rd_addr)
        |-> state_reg == ST_F_CHK)
        else $error("unexpected read and write of the same header");

    a_done_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        result.done |=> s_ready)
        else $error("result handed over without returning to idle");

endmodule

[dv/tb.sv]
// self-checking testbench for first_fit_block_allocator
// predicts each result word from its own model of the header chain
// depends on ffba_pkg and the allocator rtl
`timescale 1ns / 1ps

module tb;

    import ffba_pkg::*;

    localparam int RANDOM_ITEMS = 820;
    localparam int QUIET_LIMIT  = 4000;
    localparam int LONG_HOLD    = 400;
    localparam int TAIL_CYCLES  = 200;

    typedef struct {
        logic status;
        ofs_t offset;
    } reply_t;

    class heap_tracker;
        bit          blk_linked [ARENA_BYTES];
        int unsigned blk_next   [ARENA_BYTES];
        bit          blk_free   [ARENA_BYTES];
        int unsigned blk_size   [ARENA_BYTES];
        reply_t      pending_replies[$];
        ofs_t        granted[$];
        int          errors;

        function new();
            foreach (blk_linked[i]) begin
                blk_linked[i] = 1'b0;
                blk_next[i]   = 0;
                blk_free[i]   = 1'b0;
                blk_size[i]   = 0;
            end
            blk_free[0] = 1'b1;
            blk_size[0] = ARENA_BYTES - HEADER_BYTES;
            errors      = 0;
        endfunction

        function int pending();
            return pending_replies.size();
        endfunction

        function void merge_free_neighbours();
            int unsigned cur;
            int unsigned nx;
            int unsigned guard;
            cur   = 0;
            guard = 0;
            while (cur < ARENA_BYTES && blk_linked[cur] && guard < ARENA_BYTES) begin
                nx = blk_next[cur];
                guard++;
                if (nx >= ARENA_BYTES)
                    break;
                if (blk_free[cur] && blk_free[nx]) begin
                    blk_size[cur]   += HEADER_BYTES + blk_size[nx];
                    blk_linked[cur] = blk_linked[nx];
                    blk_next[cur]   = blk_next[nx];
                end else begin
                    cur = nx;
                end
            end
        endfunction

        // works out the reply for one accepted request word and updates the chain
        function void take_request(logic op, ofs_t req, ofs_t addr);
            reply_t      r;
            int unsigned cur;
            int unsigned guard;
            int unsigned need;
            int unsigned nb;
            int unsigned target;
            bit          hit;
            r.status = STATUS_OK;
            r.offset = '0;
            cur      = 0;
            guard    = 0;
            hit      = 1'b0;
            if (op == OP_ALLOC) begin
                need = req + HEADER_BYTES;
                while (cur < ARENA_BYTES && guard <= ARENA_BYTES) begin
                    guard++;
                    if (blk_free[cur] && blk_size[cur] >= need) begin
                        hit = 1'b1;
                        break;
                    end
                    if (!blk_linked[cur])
                        break;
                    cur = blk_next[cur];
                end
                if (!hit) begin
                    r.status = STATUS_NO_SPACE;
                end else begin
                    nb = cur + need;
                    if (nb < ARENA_BYTES) begin
                        blk_linked[nb]  = blk_linked[cur];
                        blk_next[nb]    = blk_next[cur];
                        blk_free[nb]    = 1'b1;
                        blk_size[nb]    = blk_size[cur] - need;
                        blk_linked[cur] = 1'b1;
                        blk_next[cur]   = nb;
                    end
                    blk_free[cur] = 1'b0;
                    blk_size[cur] = req;
                    r.offset      = ofs_t'(cur + HEADER_BYTES);
                    granted.push_back(r.offset);
                end
            end else if (addr >= HEADER_BYTES) begin
                target = addr - HEADER_BYTES;
                while (cur < ARENA_BYTES && guard <= ARENA_BYTES) begin
                    guard++;
                    if (cur == target) begin
                        hit = 1'b1;
                        break;
                    end
                    if (!blk_linked[cur])
                        break;
                    cur = blk_next[cur];
                end
                if (hit) begin
                    blk_free[target] = 1'b1;
                    merge_free_neighbours();
                    foreach (granted[i]) begin
                        if (granted[i] == addr) begin
                            granted.delete(i);
                            break;
                        end
                    end
                end
            end
            pending_replies.push_back(r);
        endfunction

        function void check_reply(logic status, ofs_t offset);
            reply_t want;
            if (pending_replies.size() == 0) begin
                $error("result word with nothing expected: status %0d payload_offset %0d",
                       status, offset);
                errors++;
                return;
            end
            want = pending_replies.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                errors++;
            end
            if (offset !== want.offset) begin
                $error("payload_offset: expected %0d, got %0d", want.offset, offset);
                errors++;
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic s_operation;
    ofs_t s_request_size;
    ofs_t s_address;
    logic m_valid;
    logic m_ready;
    logic m_status;
    ofs_t m_payload_offset;

    heap_tracker sb;
    int          results_seen;
    int          quiet_cycles;
    ofs_t        last_freed;

    first_fit_block_allocator dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_request_size   (s_request_size),
        .s_address        (s_address),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_payload_offset (m_payload_offset)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.take_request(s_operation, s_request_size, s_address);
            if (m_valid && m_ready) begin
                sb.check_reply(m_status, m_payload_offset);
                results_seen++;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: stall pattern is redrawn at random from four modes, plus one long hold-off
    initial begin
        int cyc;
        int mode;
        bit held;
        cyc  = 0;
        mode = 0;
        held = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (!held && results_seen >= 300) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                @(negedge aclk);
            end
            if (cyc % 64 == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= (cyc % 8) < 3;
            endcase
            cyc++;
        end
    end

    task automatic send_request(input logic op, input ofs_t req, input ofs_t addr);
        s_valid        <= 1'b1;
        s_operation    <= op;
        s_request_size <= req;
        s_address      <= addr;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (op == OP_FREE)
            last_freed = addr;
    endtask

    // n must be at least one so valid is never lowered and raised in one step
    task automatic idle_sender(input int n);
        s_valid <= 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    task automatic drain_wait();
        idle_sender(1);
        while (sb.pending() != 0)
            @(negedge aclk);
    endtask

    task automatic directed_phase();
        send_request(OP_ALLOC, 10'd0,    10'd0);
        send_request(OP_ALLOC, 10'd1023, 10'd1023);
        send_request(OP_ALLOC, 10'd976,  10'd0);
        send_request(OP_FREE,  10'd1023, 10'd24);
        // exact fit leaves an empty free block at the end of the arena
        send_request(OP_ALLOC, 10'd976,  10'd0);
        send_request(OP_ALLOC, 10'd0,    10'd0);
        send_request(OP_FREE,  10'd0,    10'd24);
        // addresses below the header size
        send_request(OP_FREE,  10'd0,    10'd0);
        send_request(OP_FREE,  10'd0,    10'd23);
        send_request(OP_ALLOC, 10'd100,  10'd0);
        send_request(OP_ALLOC, 10'd200,  10'd0);
        // addresses that are not in the chain, then the same block freed twice
        send_request(OP_FREE,  10'd0,    10'd1023);
        send_request(OP_FREE,  10'd0,    10'd500);
        send_request(OP_FREE,  10'd0,    10'd24);
        send_request(OP_FREE,  10'd0,    10'd24);
        send_request(OP_ALLOC, 10'd50,   10'd0);
        send_request(OP_FREE,  10'd0,    10'd148);
        send_request(OP_FREE,  10'd0,    10'd24);
        send_request(OP_ALLOC, 10'd512,  10'd0);
        send_request(OP_ALLOC, 10'd511,  10'd0);
        send_request(OP_ALLOC, 10'd463,  10'd0);
        send_request(OP_FREE,  10'd0,    10'd24);
        send_request(OP_FREE,  10'd0,    10'd560);
        drain_wait();
    endtask

    task automatic random_phase();
        int   good;
        int   burst;
        int   pick;
        bit   paused;
        logic op;
        ofs_t req;
        ofs_t addr;
        good   = 0;
        paused = 1'b0;
        while (good < RANDOM_ITEMS) begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            repeat (burst) begin
                pick   = $urandom_range(0, 99);
                req    = ofs_t'($urandom);
                addr   = ofs_t'($urandom);
                if (pick < 55) begin
                    op = OP_ALLOC;
                    case ($urandom_range(0, 9))
                        0: req = ofs_t'($urandom);
                        1, 2: req = ofs_t'($urandom_range(49, 300));
                        default: req = ofs_t'($urandom_range(0, 48));
                    endcase
                end else if (pick < 90 && sb.granted.size() != 0) begin
                    op   = OP_FREE;
                    addr = sb.granted[$urandom_range(0, sb.granted.size() - 1)];
                end else begin
                    op = OP_FREE;
                    case ($urandom_range(0, 2))
                        0: addr = ofs_t'($urandom_range(0, HEADER_BYTES - 1));
                        1: addr = last_freed;
                        default: ;
                    endcase
                end
                send_request(op, req, addr);
                good++;
            end
            if (!paused && good >= RANDOM_ITEMS / 2) begin
                paused = 1'b1;
                drain_wait();
            end else if ($urandom_range(0, 2) != 0) begin
                idle_sender($urandom_range(1, 12));
            end
        end
        idle_sender(1);
    endtask

    initial begin
        sb             = new();
        results_seen   = 0;
        quiet_cycles   = 0;
        last_freed     = '0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_operation    = OP_ALLOC;
        s_request_size = '0;
        s_address      = '0;
        m_ready        = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        directed_phase();
        random_phase();
        while (sb.pending() != 0)
            @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
src/ffba_pkg.sv
src/ffba_hdr_ram.sv
src/ffba_ctrl.sv
src/first_fit_block_allocator.sv
dv/tb.sv
